// ===== sv/rap_pkg.sv =====
package rap_pkg;

  // rtp header geometry
  localparam logic [15:0] HdrLen      = 16'd12;
  localparam logic [3:0]  PayloadIdx  = 4'd12;
  localparam logic [7:0]  VersionByte = 8'h80;

  // configuration register map (word index)
  localparam logic [1:0] RegSsrc = 2'd0;
  localparam logic [1:0] RegPt   = 2'd1;
  localparam logic [1:0] RegMps  = 2'd2;

  localparam logic [15:0] MpsReset = 16'd1500;

  // command queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  // one accepted item after classification
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic        pkt_end;
    logic        frm_end;
  } cmd_t;

endpackage

// ===== sv/rap_front.sv =====
module rap_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         max_packet_size_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          sample_byte_i,
  input  logic                frame_first_i,
  input  logic [15:0]         frame_length_i,
  input  logic [31:0]         frame_timestamp_i,
  input  logic                q_full_i,
  output logic                push_o,
  output rap_pkg::cmd_t       cmd_o
);

  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [15:0] frm_left_q, frm_left_d;
  logic [15:0] pkt_left_q, pkt_left_d;

  logic        accept;
  logic [15:0] fl, pl, lim, chunk, pl_eff;
  logic [31:0] ts_cur;
  logic        open_pkt;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // per-item classification and state update
  always_comb begin
    fl       = frame_first_i ? frame_length_i : frm_left_q;
    pl       = frame_first_i ? 16'd0 : pkt_left_q;
    ts_cur   = frame_first_i ? frame_timestamp_i : ts_q;
    lim      = (max_packet_size_i > rap_pkg::HdrLen) ?
               (max_packet_size_i - rap_pkg::HdrLen) : 16'd1;
    chunk    = (lim < fl) ? lim : fl;
    open_pkt = (pl == 16'd0);
    pl_eff   = open_pkt ? chunk : pl;

    seq_d      = seq_q;
    ts_d       = ts_q;
    frm_left_d = frm_left_q;
    pkt_left_d = pkt_left_q;
    push_o     = 1'b0;

    if (accept) begin
      if (fl == 16'd0) begin
        frm_left_d = fl;
        pkt_left_d = pl;
        ts_d       = ts_cur;
      end else begin
        push_o     = 1'b1;
        frm_left_d = fl - 16'd1;
        pkt_left_d = pl_eff - 16'd1;
        if (open_pkt) begin
          seq_d = seq_q + 16'd1;
          ts_d  = ts_cur + {16'd0, chunk};
        end else begin
          ts_d = ts_cur;
        end
      end
    end

    cmd_o.data    = sample_byte_i;
    cmd_o.hdr     = open_pkt;
    cmd_o.marker  = (chunk == fl);
    cmd_o.seq     = seq_q;
    cmd_o.ts      = ts_cur;
    cmd_o.pkt_end = (pl_eff == 16'd1);
    cmd_o.frm_end = (fl == 16'd1);
  end

  // packetizer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= '0;
      ts_q       <= '0;
      frm_left_q <= '0;
      pkt_left_q <= '0;
    end else begin
      seq_q      <= seq_d;
      ts_q       <= ts_d;
      frm_left_q <= frm_left_d;
      pkt_left_q <= pkt_left_d;
    end
  end

endmodule

// ===== sv/rap_fifo.sv =====
module rap_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rap_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output rap_pkg::cmd_t rdata_o,
  output logic          empty_o,
  output logic          full_o
);

  rap_pkg::cmd_t                 mem_q [rap_pkg::QDepth];
  logic [rap_pkg::QAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [rap_pkg::QCw-1:0]       count_q;
  logic                          do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == rap_pkg::QCw'(rap_pkg::QDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rap_pkg::QCw'(rap_pkg::QDepth))
    else $error("queue count out of range");
`endif

endmodule

// ===== sv/rap_back.sv =====
module rap_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   ssrc_i,
  input  logic [6:0]    payload_type_i,
  input  rap_pkg::cmd_t head_i,
  input  logic          q_empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          packet_start_o,
  output logic          packet_end_o,
  output logic          frame_end_o,
  output logic          run_last_o
);

  rap_pkg::cmd_t cur_q, cur_d;
  logic          cur_valid_q, cur_valid_d;
  logic [3:0]    idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    byte_q, byte_d;
  logic          ps_q, pe_q, fe_q, rl_q;
  logic          load, is_pay;

  assign load   = cur_valid_q && (!out_valid_q || out_ready_i);
  assign is_pay = (idx_q == rap_pkg::PayloadIdx);
  assign pop_o  = !q_empty_i && (!cur_valid_q || (load && is_pay));

  // header and payload byte select
  always_comb begin
    case (idx_q)
      4'd0:    byte_d = rap_pkg::VersionByte;
      4'd1:    byte_d = {cur_q.marker, payload_type_i};
      4'd2:    byte_d = cur_q.seq[15:8];
      4'd3:    byte_d = cur_q.seq[7:0];
      4'd4:    byte_d = cur_q.ts[31:24];
      4'd5:    byte_d = cur_q.ts[23:16];
      4'd6:    byte_d = cur_q.ts[15:8];
      4'd7:    byte_d = cur_q.ts[7:0];
      4'd8:    byte_d = ssrc_i[31:24];
      4'd9:    byte_d = ssrc_i[23:16];
      4'd10:   byte_d = ssrc_i[15:8];
      4'd11:   byte_d = ssrc_i[7:0];
      default: byte_d = cur_q.data;
    endcase
  end

  // current command sequencing
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      idx_d = idx_q + 4'd1;
      if (is_pay) begin
        cur_valid_d = 1'b0;
      end
    end
    if (pop_o) begin
      cur_d       = head_i;
      cur_valid_d = 1'b1;
      idx_d       = head_i.hdr ? 4'd0 : rap_pkg::PayloadIdx;
    end
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      byte_q <= byte_d;
      ps_q   <= (idx_q == 4'd0);
      pe_q   <= is_pay && cur_q.pkt_end;
      fe_q   <= is_pay && cur_q.frm_end;
      rl_q   <= is_pay;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign packet_start_o = ps_q;
  assign packet_end_o   = pe_q;
  assign frame_end_o    = fe_q;
  assign run_last_o     = rl_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> idx_q <= rap_pkg::PayloadIdx)
    else $error("byte index past payload");
  a_start_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && packet_start_o) |-> !run_last_o)
    else $error("header start flagged as last result");
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (packet_end_o || frame_end_o)) |-> run_last_o)
    else $error("end flag on a header byte");
`endif

endmodule

// ===== sv/rtp_audio_packetizer_top.sv =====
// an accepted payload item goes into the command queue, then the current-command
// register, then the output register, when queue and output register are empty
// throughput: one result byte per cycle at the output register while out_ready_i
// is high; an item that opens a packet yields 13 result bytes, any other item 1
// input is taken every cycle while the 4-entry command queue has room
// reset: async active low, clears all packet state; registers return to defaults
module rtp_audio_packetizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sample_byte_i,
  input  logic        frame_first_i,
  input  logic [15:0] frame_length_i,
  input  logic [31:0] frame_timestamp_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_start_o,
  output logic        packet_end_o,
  output logic        frame_end_o,
  output logic        run_last_o
);

  logic [31:0]   ssrc_q;
  logic [6:0]    pt_q;
  logic [15:0]   mps_q;
  logic          cfg_wr;
  logic          push, pop, q_full, q_empty;
  rap_pkg::cmd_t push_cmd, head_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssrc_q <= '0;
      pt_q   <= '0;
      mps_q  <= rap_pkg::MpsReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rap_pkg::RegSsrc: ssrc_q <= pwdata;
        rap_pkg::RegPt:   pt_q   <= pwdata[6:0];
        rap_pkg::RegMps:  mps_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      rap_pkg::RegSsrc: prdata = ssrc_q;
      rap_pkg::RegPt:   prdata = {25'd0, pt_q};
      rap_pkg::RegMps:  prdata = {16'd0, mps_q};
      default:          prdata = '0;
    endcase
  end

  rap_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_packet_size_i (mps_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_byte_i     (sample_byte_i),
    .frame_first_i     (frame_first_i),
    .frame_length_i    (frame_length_i),
    .frame_timestamp_i (frame_timestamp_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  rap_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  rap_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ssrc_i         (ssrc_q),
    .payload_type_i (pt_q),
    .head_i         (head_cmd),
    .q_empty_i      (q_empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .packet_start_o (packet_start_o),
    .packet_end_o   (packet_end_o),
    .frame_end_o    (frame_end_o),
    .run_last_o     (run_last_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned ResetCycles = 5;
  localparam int unsigned ItemTarget  = 350;
  localparam int unsigned PhaseItems  = 60;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned MaxReports  = 10;

  // register indexes of the map
  localparam logic [1:0] CfgSsrc = rap_pkg::RegSsrc;
  localparam logic [1:0] CfgPt   = rap_pkg::RegPt;
  localparam logic [1:0] CfgMps  = rap_pkg::RegMps;

  // register index past the end of the map, writes to it are dropped
  localparam logic [1:0] RegUnused = 2'd3;

  // one byte of the packet stream as seen on the output
  typedef struct packed {
    logic [7:0] data;
    logic       pkt_start;
    logic       pkt_end;
    logic       frm_end;
    logic       run_last;
  } pkt_byte_t;

  // directed rows: either a register write or an item, with an optional typed-in payload result
  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        first;
    logic [15:0] flen;
    logic [31:0] fts;
    logic [7:0]  smp;
    logic        lit;
    logic [3:0]  n_res;
    logic        pe;
    logic        fe;
  } dir_row_t;

  localparam int unsigned NumDir = 30;

  // kind     reg        value         first flen      fts            smp    lit  n     pe    fe
  localparam dir_row_t DirTab [NumDir] = '{
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h3C, 1'b1, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0000, 32'h0000_0000, 8'h11, 1'b1, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0001, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'd13, 1'b1, 1'b1},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h22, 1'b1, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0003, 32'h0000_0000, 8'h00, 1'b1, 4'd13, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h55, 1'b1, 4'd1, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'hFFFF, 32'h1234_5678, 8'hAA, 1'b1, 4'd13, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h01, 1'b1, 4'd1, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0000, 32'h0000_0000, 8'h02, 1'b1, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h03, 1'b1, 4'd0, 1'b0, 1'b0},
    '{RowCfg, CfgSsrc, 32'hFFFF_FFFF, 1'b0, 16'h0, 32'h0, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowCfg, CfgPt, 32'h0000_007F, 1'b0, 16'h0, 32'h0, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowCfg, CfgMps, 32'd12, 1'b0, 16'h0, 32'h0, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0002, 32'h8000_0000, 8'h5A, 1'b1, 4'd13, 1'b1, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'hA5, 1'b1, 4'd13, 1'b1, 1'b1},
    '{RowCfg, CfgMps, 32'd0, 1'b0, 16'h0, 32'h0, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0001, 32'h0000_0001, 8'h7F, 1'b1, 4'd13, 1'b1, 1'b1},
    '{RowCfg, CfgMps, 32'd14, 1'b0, 16'h0, 32'h0, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0005, 32'hFFFF_FFFE, 8'h80, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h81, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h82, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h83, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h84, 1'b1, 4'd13, 1'b1, 1'b1},
    '{RowCfg, RegUnused, 32'h0, 1'b0, 16'h0, 32'h0, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowCfg, CfgMps, 32'd13, 1'b0, 16'h0, 32'h0, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0002, 32'h0000_0000, 8'hC3, 1'b1, 4'd13, 1'b1, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0001, 32'h0000_0005, 8'h3C, 1'b1, 4'd13, 1'b1, 1'b1},
    '{RowCfg, CfgMps, 32'h0000_FFFF, 1'b0, 16'h0, 32'h0, 8'h00, 1'b0, 4'd0, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b1, 16'h0002, 32'h0000_0000, 8'h99, 1'b1, 4'd13, 1'b0, 1'b0},
    '{RowItem, CfgSsrc, 32'h0, 1'b0, 16'h0000, 32'h0000_0000, 8'h66, 1'b1, 4'd1, 1'b1, 1'b1}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  sample_byte_i;
  logic        frame_first_i;
  logic [15:0] frame_length_i;
  logic [31:0] frame_timestamp_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        packet_start_o;
  logic        packet_end_o;
  logic        frame_end_o;
  logic        run_last_o;

  // predictor copy of registers and packet state
  logic [31:0] cfg_ssrc;
  logic [6:0]  cfg_pt;
  logic [15:0] cfg_mps;
  logic [15:0] seq_num;
  logic [31:0] next_ts;
  logic [15:0] frm_left;
  logic [15:0] pkt_left;

  pkt_byte_t   item_stream [$];
  pkt_byte_t   exp_stream_q [$];
  int unsigned err_cnt = 0;

  // typed-in payload result of the directed item on the input
  logic        row_lit_on;
  logic [3:0]  row_lit_n;
  logic        row_lit_pe;
  logic        row_lit_fe;

  logic        in_gaps_on;
  logic        out_stalls_on;
  logic        out_hold_req;

  rtp_audio_packetizer_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_byte_i     (sample_byte_i),
    .frame_first_i     (frame_first_i),
    .frame_length_i    (frame_length_i),
    .frame_timestamp_i (frame_timestamp_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .packet_start_o    (packet_start_o),
    .packet_end_o      (packet_end_o),
    .frame_end_o       (frame_end_o),
    .run_last_o        (run_last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // predicted stream bytes for one accepted item, left in item_stream
  task automatic packetize(input logic [7:0] smp, input logic first,
                           input logic [15:0] flen, input logic [31:0] fts);
    logic [15:0] limit;
    logic [15:0] chunk;
    logic [95:0] hdr_bits;
    item_stream.delete();
    if (first) begin
      frm_left = flen;
      pkt_left = 16'd0;
      next_ts  = fts;
    end
    if (frm_left == 16'd0) return;
    // open a packet: header first, marker on the frame's last packet
    if (pkt_left == 16'd0) begin
      limit = (cfg_mps > rap_pkg::HdrLen) ? cfg_mps - rap_pkg::HdrLen : 16'd1;
      chunk = (limit < frm_left) ? limit : frm_left;
      hdr_bits = {rap_pkg::VersionByte, chunk == frm_left, cfg_pt, seq_num, next_ts,
                  cfg_ssrc};
      for (int i = 0; i < int'(rap_pkg::HdrLen); i++) begin
        item_stream.push_back(pkt_byte_t'{hdr_bits[95 - 8 * i -: 8], i == 0, 1'b0, 1'b0,
                                          1'b0});
      end
      seq_num  = seq_num + 16'd1;
      next_ts  = next_ts + {16'd0, chunk};
      pkt_left = chunk;
    end
    item_stream.push_back(pkt_byte_t'{smp, 1'b0, pkt_left == 16'd1, frm_left == 16'd1, 1'b1});
    pkt_left = pkt_left - 16'd1;
    frm_left = frm_left - 16'd1;
  endtask

  // apb write, setup then access, predictor follows at the write edge
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      CfgSsrc: cfg_ssrc = val;
      CfgPt:   cfg_pt   = val[6:0];
      CfgMps:  cfg_mps  = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // offer one item and hold it until accepted
  task automatic offer_item(input logic [7:0] smp, input logic first, input logic [15:0] flen,
                            input logic [31:0] fts, input logic lit, input logic [3:0] n,
                            input logic pe, input logic fe);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    sample_byte_i     = smp;
    frame_first_i     = first;
    frame_length_i    = flen;
    frame_timestamp_i = fts;
    row_lit_on        = lit;
    row_lit_n         = n;
    row_lit_pe        = pe;
    row_lit_fe        = fe;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop feeding and let every expected byte come out
  task automatic wait_stream_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (exp_stream_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // scoreboard: predict on input accept, compare on output accept
  always @(posedge clk_i) begin : scoreboard
    pkt_byte_t   got;
    pkt_byte_t   want;
    int unsigned n_hdr;
    if (in_valid_i && in_ready_o) begin
      packetize(sample_byte_i, frame_first_i, frame_length_i, frame_timestamp_i);
      // typed-in rows replace the predicted bytes; the header is kept only for a count above one
      if (row_lit_on) begin
        n_hdr = (row_lit_n > 4'd1) ? int'(rap_pkg::HdrLen) : 0;
        while (item_stream.size() > n_hdr) void'(item_stream.pop_back());
        if (row_lit_n != 4'd0) begin
          item_stream.push_back(pkt_byte_t'{sample_byte_i, 1'b0, row_lit_pe, row_lit_fe, 1'b1});
        end
      end
      foreach (item_stream[k]) exp_stream_q.push_back(item_stream[k]);
    end
    if (out_valid_o && out_ready_i) begin
      got = pkt_byte_t'{out_byte_o, packet_start_o, packet_end_o, frame_end_o, run_last_o};
      if (exp_stream_q.size() == 0) begin
        if (err_cnt < MaxReports) begin
          $display("unexpected byte: data=%02h start=%0b end=%0b frame_end=%0b last=%0b",
                   got.data, got.pkt_start, got.pkt_end, got.frm_end, got.run_last);
        end
        err_cnt++;
      end else begin
        want = exp_stream_q.pop_front();
        if (got != want) begin
          if (err_cnt < MaxReports) begin
            $display("mismatch: exp data=%02h start=%0b end=%0b frame_end=%0b last=%0b",
                     want.data, want.pkt_start, want.pkt_end, want.frm_end, want.run_last);
            $display("          got data=%02h start=%0b end=%0b frame_end=%0b last=%0b",
                     got.data, got.pkt_start, got.pkt_end, got.frm_end, got.run_last);
          end
          err_cnt++;
        end
      end
    end
  end

  // output side: random stalls per byte, one long hold on request
  initial begin : out_side
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (out_hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        out_hold_req = 1'b0;
      end
      stall = out_stalls_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("** rtp_audio_packetizer_top: FAILED **");
    $finish;
  end

  // stimulus
  initial begin : feed
    int unsigned ph;
    int unsigned counted;
    int unsigned phase_cnt;
    int unsigned pick;
    int unsigned flen;
    int unsigned to_send;
    int unsigned open_left;
    logic [31:0] fts;
    logic [31:0] mps;
    logic        cut_short;

    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_valid_i        = 1'b0;
    sample_byte_i     = '0;
    frame_first_i     = 1'b0;
    frame_length_i    = '0;
    frame_timestamp_i = '0;
    row_lit_on        = 1'b0;
    row_lit_n         = '0;
    row_lit_pe        = 1'b0;
    row_lit_fe        = 1'b0;
    in_gaps_on        = 1'b1;
    out_stalls_on     = 1'b1;
    out_hold_req      = 1'b0;
    cfg_ssrc          = '0;
    cfg_pt            = '0;
    cfg_mps           = rap_pkg::MpsReset;
    seq_num           = '0;
    next_ts           = '0;
    frm_left          = '0;
    pkt_left          = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    for (int r = 0; r < int'(NumDir); r++) begin
      if (DirTab[r].kind == RowCfg) begin
        wait_stream_drained();
        cfg_write(DirTab[r].reg_idx, DirTab[r].value);
      end else begin
        offer_item(DirTab[r].smp, DirTab[r].first, DirTab[r].flen, DirTab[r].fts,
                   DirTab[r].lit, DirTab[r].n_res, DirTab[r].pe, DirTab[r].fe);
      end
    end

    // random phases, each under its own register setting
    ph        = 0;
    counted   = 0;
    open_left = 0;
    cut_short = 1'b1;
    while (counted < ItemTarget) begin
      wait_stream_drained();
      case (ph % 6)
        0:       mps = 32'($urandom_range(13, 48));
        1:       mps = 32'($urandom_range(0, 12));
        2:       mps = 32'h0000_FFFF;
        3:       mps = 32'($urandom_range(14, 20));
        4:       mps = {16'd0, 16'($urandom())};
        default: mps = {16'd0, rap_pkg::MpsReset};
      endcase
      cfg_write(CfgSsrc, (ph % 4 == 1) ? 32'h0 : (ph % 4 == 3) ? 32'hFFFF_FFFF : $urandom());
      cfg_write(CfgPt, (ph % 3 == 0) ? 32'h0 : 32'($urandom_range(0, 127)));
      cfg_write(CfgMps, mps);
      if (ph % 3 == 2) cfg_write(RegUnused, $urandom());
      in_gaps_on    = (ph % 4 == 2) || (ph % 4 == 3);
      out_stalls_on = (ph % 4 == 0) || (ph % 4 == 3);
      // long output hold with the input running, fills the command queue
      if (ph == 1) out_hold_req = 1'b1;

      phase_cnt = 0;
      while (phase_cnt < PhaseItems) begin
        if (open_left > 0) begin
          // frame body, length and timestamp fields carry junk
          offer_item(8'($urandom()), 1'b0, 16'($urandom()), $urandom(), 1'b0, 4'd0, 1'b0,
                     1'b0);
          open_left--;
          phase_cnt++;
        end else begin
          pick = $urandom_range(0, 31);
          if (pick < 3 && !cut_short) begin
            // stray byte outside any frame
            offer_item(8'($urandom()), 1'b0, 16'($urandom()), $urandom(), 1'b0, 4'd0, 1'b0,
                       1'b0);
          end else if (pick < 5) begin
            // zero length frame abandons whatever is open
            offer_item(8'($urandom()), 1'b1, 16'd0, $urandom(), 1'b0, 4'd0, 1'b0, 1'b0);
            cut_short = 1'b0;
          end else begin
            if (pick < 8) begin
              flen    = $urandom_range(1, 65535);
              to_send = $urandom_range(1, 12);
              if (to_send > flen) to_send = flen;
            end else if (pick < 11) begin
              flen    = $urandom_range(25, 100);
              to_send = flen;
            end else begin
              flen    = $urandom_range(1, 24);
              to_send = flen;
            end
            // some frames are cut short and overrun by the next one
            if ($urandom_range(0, 7) == 0 && to_send > 1) to_send = $urandom_range(1, to_send - 1);
            cut_short = (to_send < flen);
            fts = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                              : $urandom();
            offer_item(8'($urandom()), 1'b1, 16'(flen), fts, 1'b0, 4'd0, 1'b0, 1'b0);
            open_left = to_send - 1;
            phase_cnt++;
          end
        end
      end
      counted += phase_cnt;
      ph++;
    end

    wait_stream_drained();
    if (err_cnt == 0) begin
      $display("** rtp_audio_packetizer_top: PASSED **");
    end else begin
      $display("** rtp_audio_packetizer_top: FAILED **");
    end
    $finish;
  end

endmodule
